FILE: hw/rtl/top_k_min_heap_select_macros.svh
// Assertion macros for the checker file of the top-k heap selector.
// No dependencies; include by bare file name.
`ifndef TOP_K_MIN_HEAP_SELECT_MACROS_SVH
`define TOP_K_MIN_HEAP_SELECT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define TKH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define TKH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tkh_pkg.sv
// Shared constants, types and helpers of the top-k min-heap selector.
// No dependencies; imported by every RTL module of the block.
package tkh_pkg;

    localparam int MAX_KEPT = 64;
    localparam int TAG_BITS = 64;

    localparam int WEIGHT_W = 32;
    localparam int TAG_IN_W = 64;
    localparam int SLOT_W   = 6;
    localparam int CFG_W    = 7;
    localparam int HELD_W   = 7;

    localparam int IDX_W   = $clog2(MAX_KEPT);
    localparam int CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int CHILD_W = IDX_W + 2;
    localparam int KCMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int SEL_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    localparam int IN_BITS     = WEIGHT_W + TAG_IN_W + SLOT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + HELD_W + 1 + WEIGHT_W + 1 + WEIGHT_W + TAG_IN_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD     = OUT_TDATA_W - OUT_BITS;

    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic [TAG_BITS-1:0]        t_tag;

    typedef struct packed {
        t_weight w;
        t_tag    t;
    } t_slot;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_slot            wdata;
        logic             re0;
        logic [IDX_W-1:0] raddr0;
        logic             re1;
        logic [IDX_W-1:0] raddr1;
    } t_ram_ctrl;

    typedef enum logic [1:0] {
        CMP_ROOT_NEW,
        CMP_LEFT_CUR,
        CMP_RIGHT_LEAST
    } t_cmp_sel;

    typedef struct packed {
        logic                accepted;
        logic [HELD_W-1:0]   held_count;
        logic                full_res;
        t_weight             kth_weight;
        logic                read_valid;
        t_weight             read_weight;
        logic [TAG_IN_W-1:0] read_tag;
    } t_result;

    function automatic logic [CNT_W-1:0] clamp_k(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] k;
        if (v == '0) begin
            k = CNT_W'(1);
        end else if (KCMP_W'(v) > KCMP_W'(MAX_KEPT)) begin
            k = CNT_W'(MAX_KEPT);
        end else begin
            k = CNT_W'(v);
        end
        return k;
    endfunction

    localparam logic [CNT_W-1:0] K_RESET = clamp_k(CFG_W'(16));

endpackage

FILE: hw/rtl/tkh_slot_ram.sv
// Heap slot store: one write port, two read ports with registered data.
// Depends on tkh_pkg for the slot type and depth.
module tkh_slot_ram (
    input  logic               i_clk,
    input  tkh_pkg::t_ram_ctrl i_ctrl,
    output tkh_pkg::t_slot     o_rd0,
    output tkh_pkg::t_slot     o_rd1
);
    import tkh_pkg::*;

    t_slot r_mem [MAX_KEPT];
    t_slot r_rd0;
    t_slot r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_ctrl.waddr] <= i_ctrl.wdata;
        end
        if (i_ctrl.re0) begin
            r_rd0 <= r_mem[i_ctrl.raddr0];
        end
        if (i_ctrl.re1) begin
            r_rd1 <= r_mem[i_ctrl.raddr1];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

FILE: hw/rtl/tkh_wless.sv
// Shared signed weight comparator with operand selection.
// Depends on tkh_pkg for the weight type and compare selector.
module tkh_wless (
    input  tkh_pkg::t_cmp_sel i_sel,
    input  tkh_pkg::t_weight  i_root_w,
    input  tkh_pkg::t_weight  i_new_w,
    input  tkh_pkg::t_weight  i_left_w,
    input  tkh_pkg::t_weight  i_cur_w,
    input  tkh_pkg::t_weight  i_right_w,
    input  tkh_pkg::t_weight  i_least_w,
    output logic              o_lt
);
    import tkh_pkg::*;

    t_weight opa;
    t_weight opb;

    always_comb begin
        unique case (i_sel)
            CMP_ROOT_NEW: begin
                opa = i_root_w;
                opb = i_new_w;
            end
            CMP_LEFT_CUR: begin
                opa = i_left_w;
                opb = i_cur_w;
            end
            CMP_RIGHT_LEAST: begin
                opa = i_right_w;
                opb = i_least_w;
            end
            default: begin
                opa = i_root_w;
                opb = i_new_w;
            end
        endcase
    end

    assign o_lt = opa < opb;

endmodule

FILE: hw/rtl/tkh_ctrl.sv
// Heap sequencer: fill, heapify, root replace with sift-down, and slot read.
// Depends on tkh_pkg, tkh_slot_ram and tkh_wless.
module tkh_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  tkh_pkg::t_weight              i_weight,
    input  logic [tkh_pkg::TAG_IN_W-1:0]  i_tag,
    input  logic [tkh_pkg::SLOT_W-1:0]    i_slot,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tkh_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_out_free,
    output logic                          o_res_valid,
    output tkh_pkg::t_result              o_res
);
    import tkh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_HP_LOAD,
        ST_HP_GET,
        ST_SIFT_RD,
        ST_CMP_L,
        ST_CMP_R,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_held, n_held;
    t_weight          r_root_w, n_root_w;
    t_slot            r_cur, n_cur;
    t_slot            r_least, n_least;
    logic             r_least_left, n_least_left;
    logic [IDX_W-1:0] r_at, n_at;
    logic [IDX_W-1:0] r_i, n_i;
    logic             r_heap, n_heap;
    logic             r_acc, n_acc;
    logic             r_rvalid, n_rvalid;
    t_slot            r_rslot, n_rslot;
    logic [IDX_W-1:0] r_rd_addr, n_rd_addr;

    t_ram_ctrl          ram;
    t_slot              rd0;
    t_slot              rd1;
    t_cmp_sel           cmp_sel;
    logic               lt;
    logic               finish;
    logic [CHILD_W-1:0] lc_ext;
    logic [CHILD_W-1:0] rc_ext;
    logic [CHILD_W-1:0] k_ext;
    logic               lc_in;
    logic               rc_in;
    logic [IDX_W-1:0]   lc_idx;
    logic [IDX_W-1:0]   rc_idx;
    logic               slot_hit;
    logic               full;

    tkh_slot_ram u_ram (
        .i_clk  (i_clk),
        .i_ctrl (ram),
        .o_rd0  (rd0),
        .o_rd1  (rd1)
    );

    tkh_wless u_cmp (
        .i_sel     (cmp_sel),
        .i_root_w  (r_root_w),
        .i_new_w   (i_weight),
        .i_left_w  (rd0.w),
        .i_cur_w   (r_cur.w),
        .i_right_w (rd1.w),
        .i_least_w (r_least.w),
        .o_lt      (lt)
    );

    assign lc_ext   = CHILD_W'({r_at, 1'b1});
    assign rc_ext   = lc_ext + CHILD_W'(1);
    assign k_ext    = CHILD_W'(r_k);
    assign lc_in    = lc_ext < k_ext;
    assign rc_in    = rc_ext < k_ext;
    assign lc_idx   = lc_ext[IDX_W-1:0];
    assign rc_idx   = rc_ext[IDX_W-1:0];
    assign slot_hit = SEL_W'(i_slot) < SEL_W'(r_held);
    assign full     = r_held >= r_k;

    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_held       = r_held;
        n_root_w     = r_root_w;
        n_cur        = r_cur;
        n_least      = r_least;
        n_least_left = r_least_left;
        n_at         = r_at;
        n_i          = r_i;
        n_heap       = r_heap;
        n_acc        = r_acc;
        n_rvalid     = r_rvalid;
        n_rslot      = r_rslot;
        n_rd_addr    = r_rd_addr;
        ram          = '0;
        cmp_sel      = CMP_ROOT_NEW;
        finish       = 1'b0;
        o_res_valid  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_k    = clamp_k(i_cfg_data);
                    n_held = '0;
                end else if (i_in_valid) begin
                    n_cur    = '{w: i_weight, t: i_tag[TAG_BITS-1:0]};
                    n_acc    = 1'b0;
                    n_rvalid = 1'b0;
                    n_rslot  = '0;
                    n_heap   = 1'b0;
                    if (i_mode == MODE_READ) begin
                        if (slot_hit) begin
                            n_rd_addr = IDX_W'(i_slot);
                            n_state   = ST_RD_ADDR;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else if (r_held < r_k) begin
                        n_state = ST_FILL;
                    end else begin
                        cmp_sel = CMP_ROOT_NEW;
                        if (lt) begin
                            n_acc   = 1'b1;
                            n_at    = '0;
                            n_state = ST_SIFT_RD;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_FILL: begin
                ram.we    = 1'b1;
                ram.waddr = r_held[IDX_W-1:0];
                ram.wdata = r_cur;
                n_held    = r_held + CNT_W'(1);
                n_acc     = 1'b1;
                if (r_held == r_k - CNT_W'(1)) begin
                    n_heap  = 1'b1;
                    n_i     = IDX_W'(r_k >> 1);
                    n_state = ST_HP_LOAD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_HP_LOAD: begin
                ram.re0    = 1'b1;
                ram.raddr0 = r_i;
                n_state    = ST_HP_GET;
            end
            ST_HP_GET: begin
                n_cur   = rd0;
                n_at    = r_i;
                n_state = ST_SIFT_RD;
            end
            ST_SIFT_RD: begin
                if (!lc_in) begin
                    ram.we    = 1'b1;
                    ram.waddr = r_at;
                    ram.wdata = r_cur;
                    finish    = 1'b1;
                end else begin
                    ram.re0    = 1'b1;
                    ram.raddr0 = lc_idx;
                    ram.re1    = rc_in;
                    ram.raddr1 = rc_idx;
                    n_state    = ST_CMP_L;
                end
            end
            ST_CMP_L: begin
                cmp_sel = CMP_LEFT_CUR;
                if (rc_in) begin
                    n_least      = lt ? rd0 : r_cur;
                    n_least_left = lt;
                    n_state      = ST_CMP_R;
                end else if (lt) begin
                    ram.we    = 1'b1;
                    ram.waddr = r_at;
                    ram.wdata = rd0;
                    n_at      = lc_idx;
                    n_state   = ST_SIFT_RD;
                end else begin
                    ram.we    = 1'b1;
                    ram.waddr = r_at;
                    ram.wdata = r_cur;
                    finish    = 1'b1;
                end
            end
            ST_CMP_R: begin
                cmp_sel   = CMP_RIGHT_LEAST;
                ram.we    = 1'b1;
                ram.waddr = r_at;
                if (lt) begin
                    ram.wdata = rd1;
                    n_at      = rc_idx;
                    n_state   = ST_SIFT_RD;
                end else if (r_least_left) begin
                    ram.wdata = r_least;
                    n_at      = lc_idx;
                    n_state   = ST_SIFT_RD;
                end else begin
                    ram.wdata = r_cur;
                    finish    = 1'b1;
                end
            end
            ST_RD_ADDR: begin
                ram.re0    = 1'b1;
                ram.raddr0 = r_rd_addr;
                n_state    = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                n_rslot  = rd0;
                n_rvalid = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (finish) begin
            if (r_heap && (r_i != '0)) begin
                n_i     = r_i - IDX_W'(1);
                n_state = ST_HP_LOAD;
            end else begin
                n_state = ST_DONE;
            end
        end

        if (ram.we && (ram.waddr == '0)) begin
            n_root_w = ram.wdata.w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= K_RESET;
            r_held  <= '0;
            r_heap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_held  <= n_held;
            r_heap  <= n_heap;
        end
        r_root_w     <= n_root_w;
        r_cur        <= n_cur;
        r_least      <= n_least;
        r_least_left <= n_least_left;
        r_at         <= n_at;
        r_i          <= n_i;
        r_acc        <= n_acc;
        r_rvalid     <= n_rvalid;
        r_rslot      <= n_rslot;
        r_rd_addr    <= n_rd_addr;
    end

    always_comb begin
        o_res.accepted    = r_acc;
        o_res.held_count  = HELD_W'(r_held);
        o_res.full_res    = full;
        o_res.kth_weight  = full ? r_root_w : '0;
        o_res.read_valid  = r_rvalid;
        o_res.read_weight = r_rslot.w;
        o_res.read_tag    = TAG_IN_W'(r_rslot.t);
    end

endmodule

FILE: hw/rtl/top_k_min_heap_select.sv
// Top level of the top-k min-heap selector: stream ports and result register.
// Depends on tkh_pkg and tkh_ctrl.
//
// Keeps the K largest weighted items of a stream in a min-heap of up to 64 slots.
// Input items enter on s_axis (tuser = mode, tdata = weight, tag, slot index);
// one result item per input leaves on m_axis. i_cfg_data writes K and empties
// the heap; it is taken only while the block is idle.
// One item is worked at a time; s_axis_tready stays low until its result is
// in the output register. A read fetches the addressed slot; an offer while
// filling writes the first free slot; a dropped offer goes straight to its
// result; an offer replacing the root sifts it down one heap level after another.
// The item that fills the heap also runs the bottom-up heapify, sifting down
// each node from slot K/2 down to the root.
// Each heap level costs one read of the one or two children from the slot
// memory and one or two uses of the one shared weight comparator.
// The result register holds while m_axis_tready is low; the next item can be
// accepted while a result waits, but its own result waits for that register.
// Reset empties the heap and sets K to 16; slot contents are not cleared.
module top_k_min_heap_select (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] item_weight, [95:32] item_tag, [101:96] slot_index, rest zero
    input  logic [tkh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] accepted, [7:1] held_count, [8] full_res, [40:9] kth_weight,
    // [41] read_valid, [73:42] read_weight, [137:74] read_tag, rest zero
    output logic [tkh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tkh_pkg::CFG_W-1:0]          i_cfg_data
);
    import tkh_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    res_valid;
    t_result res;

    assign out_free = !r_out_valid || m_axis_tready;

    tkh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser[0]),
        .i_weight    (s_axis_tdata[WEIGHT_W-1:0]),
        .i_tag       (s_axis_tdata[WEIGHT_W+TAG_IN_W-1:WEIGHT_W]),
        .i_slot      (s_axis_tdata[IN_BITS-1:WEIGHT_W+TAG_IN_W]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}},
                            r_out.read_tag,
                            r_out.read_weight,
                            r_out.read_valid,
                            r_out.kth_weight,
                            r_out.full_res,
                            r_out.held_count,
                            r_out.accepted};

endmodule

FILE: hw/rtl/tkh_checker.sv
// Port-level checks of the top-k min-heap selector, bound to the top level.
// Depends on tkh_pkg and top_k_min_heap_select_macros.svh.
`include "top_k_min_heap_select_macros.svh"

module tkh_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tkh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            o_cfg_ready
);
    import tkh_pkg::*;

    `TKH_ASSERT_NEXT(a_busy_after_item, s_axis_tvalid && s_axis_tready, !s_axis_tready && !o_cfg_ready, "block took a second item or config while busy")
    `TKH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed")
    `TKH_ASSERT_NOW(a_offer_no_read, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[41], "stored item also flagged as read")
    `TKH_ASSERT_NOW(a_read_zero, m_axis_tvalid && !m_axis_tdata[41], m_axis_tdata[137:42] == '0, "read data not zero without read_valid")
    `TKH_ASSERT_NOW(a_kth_zero, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[40:9] == '0 && m_axis_tdata[7:1] < 7'(MAX_KEPT), "kth weight shown while heap not full")

endmodule

bind top_k_min_heap_select tkh_checker u_tkh_checker (.*);
